FILE: design/lict_pkg.sv
// ----------------------------------------------------------------------------
// lict_pkg
// Shared constants and control/status types for the lru id cache tracker.
// ----------------------------------------------------------------------------
package lict_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CAP_REG_W  = 5;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic en;
    logic full;
  } lict_ctrl_t;

  // per-cell outcome of the request passing through it
  typedef struct packed {
    logic done;
    logic hit;
    logic evict;
  } lict_stat_t;

endpackage

FILE: design/lict_cell.sv
// ----------------------------------------------------------------------------
// lict_cell
// One recency rank of the tracker: holds an id and hands the displaced id on.
// ----------------------------------------------------------------------------
module lict_cell
  import lict_pkg::*;
#(
  parameter int K     = 0,
  parameter int ID_W  = 16,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  lict_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  input  logic [ID_W-1:0]  key,
  input  logic             in_valid,
  input  logic [ID_W-1:0]  in_id,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_id,
  output lict_stat_t       stat,
  output logic [ID_W-1:0]  ev_id
);

  localparam logic [CNT_W-1:0] RANK      = CNT_W'(K);
  localparam logic [CNT_W-1:0] RANK_NEXT = CNT_W'(K + 1);

  logic [ID_W-1:0] stored;
  logic            resident;
  logic            match;
  logic            last;
  logic            out_valid_next;

  always_comb begin
    resident = RANK < count;
    match    = resident && (stored == key);
    last     = resident && (count == RANK_NEXT);
    // stop here on a hit, at the free slot, or at the tail when full
    stat.done  = in_valid && (match || !resident || (last && ctrl.full));
    stat.hit   = in_valid && match;
    stat.evict = in_valid && !match && last && ctrl.full;
    ev_id      = stat.evict ? stored : '0;
    out_valid_next = in_valid && !stat.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.en) begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && in_valid) begin
      stored <= in_id;
      out_id <= stored;
    end
  end

endmodule

FILE: design/lict_sel.sv
// ----------------------------------------------------------------------------
// lict_sel
// Collects the outcome of whichever cell finished the request this cycle.
// ----------------------------------------------------------------------------
module lict_sel
  import lict_pkg::*;
#(
  parameter int N    = 16,
  parameter int ID_W = 16
) (
  input  lict_stat_t      stat_in [N],
  input  logic [ID_W-1:0] id_in   [N],
  output lict_stat_t      stat,
  output logic [ID_W-1:0] id
);

  // at most one cell is done at a time, so an or-tree is the select
  always_comb begin
    stat = '0;
    id   = '0;
    for (int i = 0; i < N; i++) begin
      stat = stat | stat_in[i];
      id   = id | id_in[i];
    end
  end

endmodule

FILE: design/lru_id_cache_tracker.sv
// ----------------------------------------------------------------------------
// lru_id_cache_tracker
// Fully associative lru tracker of item ids built as a row of rank cells.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  item_id
//   m_*       out  m_tvalid/m_tready  hit, evicted, evicted_id, occupancy
//   apb       in   psel/penable       capacity_in_use at address 0
//
// a request walks down the cells one rank per cycle unless the row is frozen,
// swapping ids as it goes; it stops at the hit rank, the tail rank on an
// eviction or the first free rank on an insert. no new request is taken until
// its result is registered. reset empties the tracker and sets capacity 16.
// a result held by m_tready freezes the whole row until it is taken.
// ----------------------------------------------------------------------------
module lru_id_cache_tracker
  import lict_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((ID_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // item_id
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, evicted, evicted_id, occupancy
  output logic [((ID_WIDTH + $clog2(CAPACITY + 1) + 9) / 8) * 8 - 1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int OUT_W  = 2 + ID_WIDTH + CNT_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  logic [CAP_REG_W-1:0] cap;
  logic [CNT_W-1:0]     eff_cap;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 busy;
  logic                 start;
  logic [ID_WIDTH-1:0]  key;
  logic [OUT_W-1:0]     out_word;
  lict_ctrl_t           ctrl;

  logic                 pass_v [CAPACITY];
  logic [ID_WIDTH-1:0]  pass_d [CAPACITY];
  lict_stat_t           cstat  [CAPACITY];
  logic [ID_WIDTH-1:0]  cev_id [CAPACITY];
  logic [CAPACITY-1:0]  done_vec;
  lict_stat_t           res;
  logic [ID_WIDTH-1:0]  res_id;

  // configuration
  assign pready = 1'b1;
  assign prdata = {(CFG_DATA_W-CAP_REG_W)'(0), cap};

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      cap <= pwdata[CAP_REG_W-1:0];
    end
  end

  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap) > CAPACITY) begin
      eff_cap = CNT_W'(CAPACITY);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign ctrl.en   = !(m_tvalid && !m_tready);
  assign ctrl.full = count >= eff_cap;
  assign s_tready  = !busy;

  // row of rank cells, rank 0 most recent
  for (genvar k = 0; k < CAPACITY; k++) begin : g_rank
    logic            cin_v;
    logic [ID_WIDTH-1:0] cin_d;
    if (k == 0) begin : g_head
      assign cin_v = start;
      assign cin_d = key;
    end else begin : g_body
      assign cin_v = pass_v[k-1];
      assign cin_d = pass_d[k-1];
    end
    lict_cell #(.K(k), .ID_W(ID_WIDTH), .CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (count),
      .key       (key),
      .in_valid  (cin_v),
      .in_id     (cin_d),
      .out_valid (pass_v[k]),
      .out_id    (pass_d[k]),
      .stat      (cstat[k]),
      .ev_id     (cev_id[k])
    );
    assign done_vec[k] = cstat[k].done;
  end

  lict_sel #(.N(CAPACITY), .ID_W(ID_WIDTH)) u_sel (
    .stat_in (cstat),
    .id_in   (cev_id),
    .stat    (res),
    .id      (res_id)
  );

  always_comb begin
    count_next = count;
    if (!res.hit && !res.evict) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      start    <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy  <= 1'b1;
        start <= 1'b1;
      end else if (ctrl.en) begin
        start <= 1'b0;
      end
      if (ctrl.en && res.done) begin
        busy     <= 1'b0;
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      key <= s_tdata[ID_WIDTH-1:0];
    end
    if (ctrl.en && res.done) begin
      out_word <= {count_next, res_id, res.evict, res.hit};
    end
  end

  assign m_tdata = OUT_TW'(out_word);

  // checks
  a_one_done: assert property (@(posedge clk) disable iff (rst) $onehot0(done_vec))
    else $error("more than one cell finished a request");
  a_count_max: assert property (@(posedge clk) disable iff (rst) 32'(count) <= CAPACITY)
    else $error("occupancy beyond capacity");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |-> busy)
    else $error("request in the row while idle");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !pass_v[CAPACITY-1])
    else $error("request ran off the end of the row");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      (ctrl.en && res.done) |=> (!busy && m_tvalid))
    else $error("finished request left the tracker busy");

endmodule
